// File: src/text_markup_cursor_parser_assert.svh
// Assertion macros shared by the text markup cursor parser modules.
`ifndef TEXT_MARKUP_CURSOR_PARSER_ASSERT_SVH
`define TEXT_MARKUP_CURSOR_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TMCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TMCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tmcp_pkg.sv
// Shared types and constants of the text markup cursor parser.
package tmcp_pkg;

    localparam int COLUMN_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int TAB_BITS   = 5;
    localparam int COLOR_BITS = 24;

    localparam logic [TAB_BITS-1:0]   TAB_STOP_RESET = 5'd4;
    localparam logic [COLOR_BITS-1:0] COLOR_WHITE    = 24'hFFFFFF;
    localparam logic [COLOR_BITS-1:0] COLOR_BLACK    = 24'h000000;

    // Cursor work handed from front to back.
    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_GLYPH   = 3'd1,
        OP_NEWLINE = 3'd2,
        OP_TAB     = 3'd3,
        OP_BACK    = 3'd4
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [7:0]            glyph;
        logic [COLOR_BITS-1:0] fg;
        logic [COLOR_BITS-1:0] bg;
        logic                  bg_on;
        logic                  last;
    } entry_t;

endpackage

// File: src/tmcp_front.sv
// Front end: accepts text bytes, runs the markup parser and colors, queues cursor work.
module tmcp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        char_code,
    input  logic              last,
    input  logic              q_full,
    output logic              q_push,
    output tmcp_pkg::entry_t  q_entry
);

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_NL  = 8'h0A;
    localparam logic [7:0] CHAR_BAR = 8'h7C;
    localparam logic [7:0] CHAR_LC  = 8'h63;
    localparam logic [7:0] CHAR_UC  = 8'h43;
    localparam logic [7:0] CHAR_R   = 8'h72;
    localparam logic [2:0] HEX_LAST = 3'd5;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_BAR    = 4'b0010,
        MODE_FG_HEX = 4'b0100,
        MODE_BG_HEX = 4'b1000
    } mode_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
        return v;
    endfunction

    mode_t                          mode_reg, mode_next;
    logic [2:0]                     cnt_reg, cnt_next;
    logic [tmcp_pkg::COLOR_BITS-1:0] acc_reg, acc_next;
    logic [tmcp_pkg::COLOR_BITS-1:0] fg_reg, fg_next;
    logic [tmcp_pkg::COLOR_BITS-1:0] bg_reg, bg_next;
    logic                           bg_en_reg, bg_en_next;

    logic           accept;
    tmcp_pkg::op_t  norm_op;
    logic           norm_bar;
    tmcp_pkg::op_t  op;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    // Plain byte classification.
    always_comb begin
        norm_bar = 1'b0;
        unique case (char_code)
            CHAR_NL:  norm_op = tmcp_pkg::OP_NEWLINE;
            CHAR_TAB: norm_op = tmcp_pkg::OP_TAB;
            CHAR_BS:  norm_op = tmcp_pkg::OP_BACK;
            CHAR_NUL: norm_op = tmcp_pkg::OP_NONE;
            CHAR_BAR: begin
                norm_op  = tmcp_pkg::OP_NONE;
                norm_bar = 1'b1;
            end
            default:  norm_op = tmcp_pkg::OP_GLYPH;
        endcase
    end

    always_comb begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        bg_en_next = bg_en_reg;
        op         = tmcp_pkg::OP_NONE;
        if (accept) begin
            unique case (mode_reg)
                MODE_FG_HEX, MODE_BG_HEX: begin
                    acc_next = {acc_reg[tmcp_pkg::COLOR_BITS-5:0], hex_value(char_code)};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == HEX_LAST) begin
                        if (mode_reg == MODE_FG_HEX) fg_next = acc_next;
                        else bg_next = acc_next;
                        mode_next = MODE_NORMAL;
                        cnt_next  = '0;
                        acc_next  = '0;
                    end
                end
                MODE_BAR: begin
                    mode_next = MODE_NORMAL;
                    if (char_code == CHAR_LC) begin
                        mode_next = MODE_FG_HEX;
                        cnt_next  = '0;
                        acc_next  = '0;
                    end else if (char_code == CHAR_UC) begin
                        mode_next  = MODE_BG_HEX;
                        bg_en_next = 1'b1;
                        cnt_next   = '0;
                        acc_next   = '0;
                    end else if (char_code == CHAR_R) begin
                        fg_next    = tmcp_pkg::COLOR_WHITE;
                        bg_en_next = 1'b0;
                    end else if (char_code == CHAR_BAR) begin
                        op = tmcp_pkg::OP_GLYPH;
                    end else begin
                        op = norm_op;
                        if (norm_bar) mode_next = MODE_BAR;
                    end
                end
                MODE_NORMAL: begin
                    op = norm_op;
                    if (norm_bar) mode_next = MODE_BAR;
                end
                default: mode_next = MODE_NORMAL;
            endcase
            if (last) begin
                mode_next = MODE_NORMAL;
                cnt_next  = '0;
                acc_next  = '0;
            end
        end
    end

    // A glyph never changes colors on its own byte, so the current colors go along.
    assign q_push        = accept && (op != tmcp_pkg::OP_NONE || last);
    assign q_entry.op    = op;
    assign q_entry.glyph = char_code;
    assign q_entry.fg    = fg_reg;
    assign q_entry.bg    = bg_reg;
    assign q_entry.bg_on = bg_en_reg;
    assign q_entry.last  = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NORMAL;
            cnt_reg   <= '0;
            acc_reg   <= '0;
            fg_reg    <= tmcp_pkg::COLOR_WHITE;
            bg_reg    <= tmcp_pkg::COLOR_BLACK;
            bg_en_reg <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            bg_en_reg <= bg_en_next;
        end
    end

endmodule

// File: src/tmcp_queue.sv
// Small FIFO of cursor work between front and back.
module tmcp_queue #(
    parameter int DEPTH = tmcp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tmcp_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output tmcp_pkg::entry_t  head
);

    `include "text_markup_cursor_parser_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tmcp_pkg::entry_t  store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push) cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (do_push) store_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `TMCP_ASSERT_NOW(a_no_push_full, full, !push, "front pushed into a full queue")
    `TMCP_ASSERT_NOW(a_no_pop_empty, !valid, !pop, "back popped an empty queue")
    `TMCP_ASSERT_NEXT(a_fill_tracks, (do_push && !do_pop), (cnt_reg == $past(cnt_reg) + CNT_W'(1)),
                      "queue fill count lost a push")

endmodule

// File: src/tmcp_back.sv
// Back end: cursor column and line, tab remainder unit, glyph output register.
module tmcp_back #(
    parameter int COLUMN_BITS = tmcp_pkg::COLUMN_BITS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tmcp_pkg::TAB_BITS-1:0] tab_stop,
    input  logic                          q_valid,
    input  tmcp_pkg::entry_t              q_head,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_glyph,
    output logic [15:0]                   m_column,
    output logic [15:0]                   m_line,
    output logic [tmcp_pkg::COLOR_BITS-1:0] m_fg,
    output logic [tmcp_pkg::COLOR_BITS-1:0] m_bg,
    output logic                          m_bg_on
);

    `include "text_markup_cursor_parser_assert.svh"

    localparam int N     = COLUMN_BITS;
    localparam int W     = COLUMN_BITS + 2;
    localparam int CNT_W = $clog2(COLUMN_BITS);
    localparam int TB    = tmcp_pkg::TAB_BITS;

    localparam logic signed [W-1:0] COL_MAX = $signed({3'b000, {(N-1){1'b1}}});
    localparam logic signed [W-1:0] COL_MIN = $signed({3'b111, {(N-1){1'b0}}});

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIX  = 3'b100
    } state_t;

    function automatic logic signed [N-1:0] clamp(input logic signed [W-1:0] v);
        logic signed [N-1:0] r;
        if (v > COL_MAX) r = COL_MAX[N-1:0];
        else if (v < COL_MIN) r = COL_MIN[N-1:0];
        else r = v[N-1:0];
        return r;
    endfunction

    state_t                   state_reg, state_next;
    logic signed [N-1:0]      col_reg, col_next;
    logic [15:0]              line_reg, line_next;
    logic [N-1:0]             mag_reg, mag_next;
    logic [TB-1:0]            rem_reg, rem_next;
    logic [TB-1:0]            step_reg, step_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     tlast_reg, tlast_next;

    logic                     m_valid_reg, m_valid_next;
    logic [7:0]               glyph_reg;
    logic [15:0]              column_reg;
    logic [15:0]              line_out_reg;
    logic [tmcp_pkg::COLOR_BITS-1:0] fg_reg, bg_reg;
    logic                     bg_on_reg;
    logic                     load_out;

    logic                     out_free;
    logic signed [W-1:0]      col_wide, step_wide, rem_wide;
    logic [TB-1:0]            step_eff;
    logic [TB:0]              trial;

    assign out_free  = !m_valid_reg || m_ready;
    assign col_wide  = $signed({{2{col_reg[N-1]}}, col_reg});
    assign step_wide = $signed({{(W-TB){1'b0}}, step_reg});
    assign rem_wide  = $signed({{(W-TB){1'b0}}, rem_reg});
    assign step_eff  = (tab_stop == '0) ? TB'(1) : tab_stop;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid
                     && (q_head.op != tmcp_pkg::OP_GLYPH || out_free);

    // One restoring remainder step per cycle, magnitude bits MSB first.
    always_comb begin
        trial = {rem_reg, mag_reg[N-1]};
        if (trial >= {1'b0, step_reg}) trial = trial - {1'b0, step_reg};
    end

    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        line_next    = line_reg;
        mag_next     = mag_reg;
        rem_next     = rem_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        tlast_next   = tlast_reg;
        load_out     = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    unique case (q_head.op)
                        tmcp_pkg::OP_GLYPH: begin
                            load_out     = 1'b1;
                            m_valid_next = 1'b1;
                            col_next     = clamp(col_wide + W'(1));
                        end
                        tmcp_pkg::OP_NEWLINE: begin
                            col_next = '0;
                            if (line_reg != 16'hFFFF) line_next = line_reg + 16'd1;
                        end
                        tmcp_pkg::OP_BACK: col_next = clamp(col_wide - W'(1));
                        tmcp_pkg::OP_TAB: begin
                            state_next = ST_DIV;
                            mag_next   = col_reg[N-1] ? N'(-col_reg) : N'(col_reg);
                            rem_next   = '0;
                            step_next  = step_eff;
                            cnt_next   = '0;
                            tlast_next = q_head.last;
                        end
                        default: ;
                    endcase
                    if (q_head.last && q_head.op != tmcp_pkg::OP_TAB) begin
                        col_next  = '0;
                        line_next = '0;
                    end
                end
            end
            ST_DIV: begin
                rem_next = trial[TB-1:0];
                mag_next = {mag_reg[N-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(N - 1)) state_next = ST_FIX;
            end
            ST_FIX: begin
                // Remainder takes the sign of the column.
                if (col_reg[N-1]) col_next = clamp(col_wide + step_wide + rem_wide);
                else col_next = clamp(col_wide + step_wide - rem_wide);
                if (tlast_reg) begin
                    col_next  = '0;
                    line_next = '0;
                end
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            line_reg    <= '0;
            cnt_reg     <= '0;
            tlast_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            line_reg    <= line_next;
            cnt_reg     <= cnt_next;
            tlast_reg   <= tlast_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg  <= mag_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (load_out) begin
            glyph_reg    <= q_head.glyph;
            column_reg   <= 16'(col_reg);
            line_out_reg <= line_reg;
            fg_reg       <= q_head.fg;
            bg_reg       <= q_head.bg;
            bg_on_reg    <= q_head.bg_on;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_glyph  = glyph_reg;
    assign m_column = column_reg;
    assign m_line   = line_out_reg;
    assign m_fg     = fg_reg;
    assign m_bg     = bg_reg;
    assign m_bg_on  = bg_on_reg;

    `TMCP_ASSERT_NOW(a_pop_only_idle, (state_reg != ST_IDLE), !q_pop,
                     "queue popped while a tab is in progress")
    `TMCP_ASSERT_NOW(a_rem_below_step, (state_reg == ST_FIX), (rem_reg < step_reg),
                     "tab remainder not below the tab stop")
    `TMCP_ASSERT_NEXT(a_glyph_shows, (q_pop && q_head.op == tmcp_pkg::OP_GLYPH), m_valid_reg,
                      "popped glyph did not reach the output register")

endmodule

// File: src/text_markup_cursor_parser.sv
// Top level of the text markup cursor parser: config register, front, queue and back.
//
// Takes one text byte per cycle on s_axis while the queue is not full and gives one m_axis
// item per glyph with its column, line and current colors. Markup ('|c' / '|C' + six hex
// digits, '|r', '||') is parsed in the front end, which also holds the colors; cursor moves go
// through a short queue to the back end, which owns the column and line. In the back end a
// tab's remainder by the tab stop is found one column bit per cycle by a restoring remainder
// unit, and the queue lets the front keep taking bytes meanwhile until it fills. A byte with
// s_axis_tlast set returns the cursor to column 0, line 0 and drops any unfinished command;
// colors are kept. The column saturates to the signed COLUMN_BITS range and the line at 65535.
// tab_stop is written through cfg_wr_en / cfg_wr_data (0 acts as 1, reset 4); the user must
// write it only while the block is idle, which the block itself does not enforce.
module text_markup_cursor_parser #(
    parameter int COLUMN_BITS = tmcp_pkg::COLUMN_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = tmcp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [tmcp_pkg::TAB_BITS-1:0] cfg_wr_data,   // tab_stop
    // text byte in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] char_code
    input  logic                          s_axis_tlast,  // last
    // glyph out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] glyph, [23:8] column, [39:24] line, [47:40] fg_red, [55:48] fg_green,
    // [63:56] fg_blue, [71:64] bg_red, [79:72] bg_green, [87:80] bg_blue
    output logic [87:0]                   m_axis_tdata,
    output logic                          m_axis_tuser   // bg_on
);

    logic [tmcp_pkg::TAB_BITS-1:0] tab_stop_reg;

    logic              q_push, q_full, q_pop, q_valid;
    tmcp_pkg::entry_t  push_entry, head_entry;

    logic [7:0]                      glyph;
    logic [15:0]                     column, line;
    logic [tmcp_pkg::COLOR_BITS-1:0] fg, bg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tab_stop_reg <= tmcp_pkg::TAB_STOP_RESET;
        end else if (cfg_wr_en) begin
            tab_stop_reg <= cfg_wr_data;
        end
    end

    tmcp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .char_code (s_axis_tdata),
        .last      (s_axis_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    tmcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .head       (head_entry)
    );

    tmcp_back #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tab_stop (tab_stop_reg),
        .q_valid  (q_valid),
        .q_head   (head_entry),
        .q_pop    (q_pop),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_glyph  (glyph),
        .m_column (column),
        .m_line   (line),
        .m_fg     (fg),
        .m_bg     (bg),
        .m_bg_on  (m_axis_tuser)
    );

    // Colors are held as 0xRRGGBB; red goes lowest on the bus.
    assign m_axis_tdata = {bg[7:0], bg[15:8], bg[23:16],
                           fg[7:0], fg[15:8], fg[23:16],
                           line, column, glyph};

endmodule

// File: verif/text_markup_cursor_parser_tb.sv
// Self-checking testbench of the text markup cursor parser: stream stimulus, prediction, checks.
module text_markup_cursor_parser_tb;

    // Control and markup bytes of the text stream.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_BAR = 8'h7C;   // '|'
    localparam logic [7:0] CH_FG  = 8'h63;   // 'c'
    localparam logic [7:0] CH_BG  = 8'h43;   // 'C'
    localparam logic [7:0] CH_RST = 8'h72;   // 'r'

    localparam int COL_MAX  = 32767;
    localparam int COL_MIN  = -32768;
    localparam int LINE_TOP = 65535;

    // Cycles to let the back end drain queued tabs once no glyph is pending.
    localparam int SETTLE_CYCLES = 200;

    typedef enum logic [1:0] {
        PM_NORMAL,
        PM_BAR,
        PM_FG_HEX,
        PM_BG_HEX
    } parse_mode_t;

    typedef struct packed {
        logic [7:0]  glyph;
        logic [15:0] column;
        logic [15:0] line;
        logic [23:0] fg;
        logic [23:0] bg;
        logic        bg_on;
    } glyph_cell_t;

    // Tracks cursor, colors and markup state; holds the glyphs still to come out.
    class glyph_predictor;
        logic [4:0]            tab_stop;
        parse_mode_t           mode;
        int                    hex_count;
        logic [23:0]           hex_accum;
        int                    col;
        int                    line;
        logic [23:0]           fg;
        logic [23:0]           bg;
        logic                  bg_on;
        glyph_cell_t           expected_glyphs[$];
        int                    errors;

        function new();
            tab_stop  = tmcp_pkg::TAB_STOP_RESET;
            mode      = PM_NORMAL;
            hex_count = 0;
            hex_accum = '0;
            col       = 0;
            line      = 0;
            fg        = tmcp_pkg::COLOR_WHITE;
            bg        = tmcp_pkg::COLOR_BLACK;
            bg_on     = 1'b0;
            errors    = 0;
        endfunction

        function int clamp_col(int v);
            if (v > COL_MAX) return COL_MAX;
            if (v < COL_MIN) return COL_MIN;
            return v;
        endfunction

        function logic [3:0] hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9") return 4'(c - "0");
            if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
            if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
            return 4'd0;
        endfunction

        function void emit(logic [7:0] c);
            glyph_cell_t g;
            g.glyph  = c;
            g.column = col[15:0];
            g.line   = line[15:0];
            g.fg     = fg;
            g.bg     = bg;
            g.bg_on  = bg_on;
            expected_glyphs.push_back(g);
            col = clamp_col(col + 1);
        endfunction

        function void plain_byte(logic [7:0] c);
            int t;
            case (c)
                CH_NL: begin
                    col = 0;
                    if (line < LINE_TOP) line++;
                end
                CH_TAB: begin
                    t = (tab_stop == 0) ? 1 : int'(tab_stop);
                    // SV % truncates toward zero, as the block expects
                    col = clamp_col(col + t - (col % t));
                end
                CH_BS:   col = clamp_col(col - 1);
                CH_NUL:  ;
                CH_BAR:  mode = PM_BAR;
                default: emit(c);
            endcase
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            case (mode)
                PM_FG_HEX, PM_BG_HEX: begin
                    hex_accum = {hex_accum[19:0], hex_nibble(c)};
                    hex_count++;
                    if (hex_count >= 6) begin
                        if (mode == PM_FG_HEX) fg = hex_accum;
                        else bg = hex_accum;
                        mode      = PM_NORMAL;
                        hex_count = 0;
                        hex_accum = '0;
                    end
                end
                PM_BAR: begin
                    mode = PM_NORMAL;
                    if (c == CH_FG || c == CH_BG) begin
                        mode = (c == CH_FG) ? PM_FG_HEX : PM_BG_HEX;
                        if (c == CH_BG) bg_on = 1'b1;
                        hex_count = 0;
                        hex_accum = '0;
                    end else if (c == CH_RST) begin
                        fg    = tmcp_pkg::COLOR_WHITE;
                        bg_on = 1'b0;
                    end else if (c == CH_BAR) begin
                        emit(c);
                    end else begin
                        plain_byte(c);
                    end
                end
                default: plain_byte(c);
            endcase
            if (last) begin
                mode      = PM_NORMAL;
                hex_count = 0;
                hex_accum = '0;
                col       = 0;
                line      = 0;
            end
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            end
        endfunction

        function void check_glyph(logic [87:0] data, logic user);
            glyph_cell_t g;
            if (expected_glyphs.size() == 0) begin
                errors++;
                $display("%0t: unexpected glyph, expected none, actual data 0x%0h bg_on %0b",
                         $time, data, user);
                return;
            end
            g = expected_glyphs.pop_front();
            cmp_field("glyph",    16'(g.glyph),      16'(data[7:0]));
            cmp_field("column",   g.column,          data[23:8]);
            cmp_field("line",     g.line,            data[39:24]);
            cmp_field("fg_red",   16'(g.fg[23:16]),  16'(data[47:40]));
            cmp_field("fg_green", 16'(g.fg[15:8]),   16'(data[55:48]));
            cmp_field("fg_blue",  16'(g.fg[7:0]),    16'(data[63:56]));
            cmp_field("bg_red",   16'(g.bg[23:16]),  16'(data[71:64]));
            cmp_field("bg_green", 16'(g.bg[15:8]),   16'(data[79:72]));
            cmp_field("bg_blue",  16'(g.bg[7:0]),    16'(data[87:80]));
            cmp_field("bg_on",    16'(g.bg_on),      16'(user));
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] char_code
    logic        s_axis_tlast;    // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] glyph, [23:8] column, [39:24] line, [47:40] fg_red, [55:48] fg_green,
    // [63:56] fg_blue, [71:64] bg_red, [79:72] bg_green, [87:80] bg_blue
    logic [87:0] m_axis_tdata;
    logic        m_axis_tuser;    // bg_on

    glyph_predictor pred;
    bit             steady;       // no idling on either side while set
    int             bytes_sent;   // non-NUL bytes accepted

    text_markup_cursor_parser DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Overall guard against a hung handshake.
    initial begin
        #30_000_000;
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps, a few long ones.
    function int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls.
    initial begin
        int n;
        m_axis_tready = 1'b0;
        @(negedge aclk);
        forever begin
            n = pick_gap();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge aclk);
        end
    end

    // Check every accepted glyph against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            pred.check_glyph(m_axis_tdata, m_axis_tuser);
    end

    // Present one byte, wait for the handshake, then update the prediction.
    // Called and returns at a falling edge.
    task automatic send_byte(logic [7:0] c, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        pred.note_byte(c, last);
        if (c != CH_NUL) bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(string s, logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    task automatic send_repeat(logic [7:0] c, int n);
        repeat (n) send_byte(c, 1'b0);
    endtask

    // Drain all glyphs and the tab work behind them, then write tab_stop.
    task automatic write_tab_stop(logic [4:0] v);
        s_axis_tvalid <= 1'b0;
        while (pred.expected_glyphs.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        pred.tab_stop = v;
        @(negedge aclk);
    endtask

    function logic [7:0] pick_hex_digit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'("0" + $urandom_range(0, 9));
        if (r < 65) return 8'("a" + $urandom_range(0, 5));
        if (r < 90) return 8'("A" + $urandom_range(0, 5));
        return 8'($urandom_range(0, 255));   // not a digit: counts as zero
    endfunction

    function logic [7:0] pick_glyph();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == CH_NUL || c == CH_BS || c == CH_TAB || c == CH_NL || c == CH_BAR);
        return c;
    endfunction

    function logic pick_last();
        return ($urandom_range(0, 49) == 0);
    endfunction

    // One random token: mostly well-formed markup and cursor moves, some noise.
    task automatic random_token();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            send_byte(pick_glyph(), pick_last());
        end else if (r < 45) begin
            send_byte(CH_NL, pick_last());
        end else if (r < 55) begin
            send_byte(CH_TAB, pick_last());
        end else if (r < 62) begin
            repeat ($urandom_range(1, 6)) send_byte(CH_BS, pick_last());
        end else if (r < 65) begin
            send_byte(CH_NUL, pick_last());
        end else if (r < 80) begin
            send_byte(CH_BAR, pick_last());
            send_byte($urandom_range(0, 1) ? CH_FG : CH_BG, pick_last());
            repeat (6) send_byte(pick_hex_digit(), pick_last());
        end else if (r < 85) begin
            send_byte(CH_BAR, pick_last());
            send_byte(CH_RST, pick_last());
        end else if (r < 89) begin
            send_byte(CH_BAR, pick_last());
            send_byte(CH_BAR, pick_last());
        end else if (r < 94) begin
            // stray bar: the next byte is handled as plain text
            send_byte(CH_BAR, pick_last());
            send_byte(8'($urandom_range(0, 255)), pick_last());
        end else begin
            send_byte(8'($urandom_range(0, 255)), pick_last());
        end
    endtask

    task automatic run_random(int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 99) == 0) steady = ($urandom_range(0, 2) == 0);
            random_token();
        end
        steady = 1'b0;
    endtask

    initial begin
        logic [4:0] stops[6];
        pred          = new();
        steady        = 1'b0;
        bytes_sent    = 0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: glyph extremes, cursor moves, NUL, every command, stray bars,
        // a color command cut by the last mark, a lone bar cut by the last mark.
        send_byte("A", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_TAB, 1'b0);
        send_byte(CH_BS, 1'b0);
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_text("|cF0a9Zz", 1'b0);
        send_text("|C12", 1'b1);
        send_text("|r", 1'b0);
        send_text("||", 1'b0);
        send_text("|q", 1'b0);
        send_byte(CH_BAR, 1'b1);

        // Random phases over several tab stops, the extremes among them.
        stops = '{tmcp_pkg::TAB_STOP_RESET, 5'd1, 5'd16, 5'd0, 5'd31, 5'd0};
        stops[5] = 5'($urandom_range(2, 15));
        foreach (stops[i]) begin
            write_tab_stop(stops[i]);
            run_random(240);
        end

        // Tabs from negative columns, remainder truncated toward zero.
        write_tab_stop(5'd5);
        steady = 1'b1;
        send_byte(CH_NL, 1'b1);
        send_repeat(CH_BS, 23);
        send_text("x\010\010y\tz\010\tw", 1'b0);
        send_byte(CH_NL, 1'b1);

        // Wide tabs.
        write_tab_stop(5'd31);
        steady = 1'b1;
        send_repeat(CH_TAB, 6);
        send_text("pq\tr", 1'b1);

        // A run of newlines.
        send_repeat(CH_NL, 24);
        send_text("end", 1'b1);
        steady = 1'b0;

        // Drain and let any tab work settle before judging.
        s_axis_tvalid <= 1'b0;
        while (pred.expected_glyphs.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (pred.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/tmcp_pkg.sv
src/tmcp_front.sv
src/tmcp_queue.sv
src/tmcp_back.sv
src/text_markup_cursor_parser.sv
verif/text_markup_cursor_parser_tb.sv
